[hdl/rmd_pkg.sv]
// Shared types and constants for the record marking deframer.
`timescale 1ns / 1ps

package rmd_pkg;

    localparam int unsigned LEN_W   = 31;
    localparam int unsigned MARK_W  = 24;
    localparam int unsigned CNT_W   = 2;
    localparam int unsigned KIND_W  = 3;

    localparam logic [LEN_W-1:0] MAX_LEN_RESET = 31'd65536;
    localparam logic [CNT_W-1:0] MARK_LAST_CNT = 2'd3;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_PAYLOAD   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_EMPTY     = 3'd1;
    localparam logic [KIND_W-1:0] KIND_BREAK     = 3'd2;
    localparam logic [KIND_W-1:0] KIND_BAD_MARK  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_TOO_LARGE = 3'd4;

    typedef struct packed {
        logic [MARK_W-1:0] marker_bytes;
        logic [CNT_W-1:0]  marker_count;
        logic [LEN_W-1:0]  bytes_left;
        logic              failed;
    } rmd_state_t;

    typedef struct packed {
        logic              valid;
        logic [KIND_W-1:0] kind;
        logic [7:0]        data_byte;
        logic              last;
    } rmd_result_t;

endpackage

[hdl/rmd_step.sv]
// Per-byte framing logic: next state and optional result for one byte.
`timescale 1ns / 1ps

module rmd_step
(
    input  rmd_pkg::rmd_state_t          state_cur,
    input  logic [7:0]                   in_byte,
    input  logic [rmd_pkg::LEN_W-1:0]    max_len,
    output rmd_pkg::rmd_state_t          state_nxt,
    output rmd_pkg::rmd_result_t         result
);
    import rmd_pkg::*;

    logic [31:0]      marker;
    logic [LEN_W-1:0] len;

    assign marker = {state_cur.marker_bytes, in_byte};
    assign len    = marker[LEN_W-1:0];

    // Decide what this byte is: dropped after a failure, payload, marker byte or marker completion
    always_comb
    begin
        state_nxt = state_cur;
        result    = '0;

        if (state_cur.failed)
        begin
            // latched failure: byte dropped
        end
        else if (state_cur.bytes_left != '0)
        begin
            state_nxt.bytes_left = state_cur.bytes_left - LEN_W'(1);
            result.valid     = 1'b1;
            result.kind      = KIND_PAYLOAD;
            result.data_byte = in_byte;
            result.last      = (state_cur.bytes_left == LEN_W'(1));
        end
        else if (state_cur.marker_count != MARK_LAST_CNT)
        begin
            state_nxt.marker_bytes = {state_cur.marker_bytes[MARK_W-9:0], in_byte};
            state_nxt.marker_count = state_cur.marker_count + CNT_W'(1);
        end
        else
        begin
            state_nxt.marker_bytes = '0;
            state_nxt.marker_count = '0;
            if (marker == 32'd0)
            begin
                state_nxt.failed = 1'b1;
                result.valid     = 1'b1;
                result.kind      = KIND_BREAK;
            end
            else if (!marker[31])
            begin
                state_nxt.failed = 1'b1;
                result.valid     = 1'b1;
                result.kind      = KIND_BAD_MARK;
            end
            else if (len > max_len)
            begin
                state_nxt.failed = 1'b1;
                result.valid     = 1'b1;
                result.kind      = KIND_TOO_LARGE;
            end
            else if (len == '0)
            begin
                result.valid = 1'b1;
                result.kind  = KIND_EMPTY;
                result.last  = 1'b1;
            end
            else
            begin
                state_nxt.bytes_left = len;
            end
        end
    end

endmodule

[hdl/record_marking_deframer.sv]
// Top level of the record marking deframer: framing state, result register.
//
//  Channel  | Signals                               | Direction
//  ---------+---------------------------------------+----------
//  input    | in_valid, in_ready, in_byte           | in
//  result   | out_valid, out_ready, kind,           | out
//           | data_byte, last                       |
//  config   | cfg_we, cfg_data                      | in
//
// One byte per cycle unless the output stalls: each transaction passes through
// the step logic into the result register. in_ready is high whenever the result
// register is empty or is being emptied in the same cycle, so a stall on the
// output holds the input only once a result is waiting. Reset clears the
// framing state, the failure latch and the result register, and loads the
// maximum length with 65536.
`timescale 1ns / 1ps

module record_marking_deframer
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [7:0]                    in_byte,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [rmd_pkg::KIND_W-1:0]    kind,
    output logic [7:0]                    data_byte,
    output logic                          last,
    input  logic                          cfg_we,
    input  logic [rmd_pkg::LEN_W-1:0]     cfg_data
);
    import rmd_pkg::*;

    rmd_state_t       st_reg;
    rmd_state_t       st_next;
    rmd_result_t      res_next;
    rmd_result_t      out_reg;
    logic [LEN_W-1:0] max_len_reg;
    logic             in_acc;

    assign in_ready = !out_reg.valid || out_ready;
    assign in_acc   = in_valid && in_ready;

    rmd_step u_step
    (
        .state_cur (st_reg),
        .in_byte   (in_byte),
        .max_len   (max_len_reg),
        .state_nxt (st_next),
        .result    (res_next)
    );

    // Maximum length register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_len_reg <= MAX_LEN_RESET;
        else if (cfg_we)
            max_len_reg <= cfg_data;
    end

    // Framing state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_reg <= '0;
        else if (in_acc)
            st_reg <= st_next;
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_reg <= '0;
        else if (in_acc)
            out_reg <= res_next;
        else if (out_ready)
            out_reg.valid <= 1'b0;
    end

    assign out_valid = out_reg.valid;
    assign kind      = out_reg.kind;
    assign data_byte = out_reg.data_byte;
    assign last      = out_reg.last;

    // Failure latch never clears outside reset
    a_failed_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg.failed |=> st_reg.failed)
        else $error("failure latch cleared");

    // Payload count and marker gathering are exclusive
    a_left_no_marker: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg.bytes_left != '0) |-> (st_reg.marker_count == '0))
        else $error("marker bytes gathered during payload");

    // A break or error result is always accompanied by the failure latch
    a_fail_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_reg.valid && (out_reg.kind == KIND_BREAK ||
                           out_reg.kind == KIND_BAD_MARK ||
                           out_reg.kind == KIND_TOO_LARGE)) |-> st_reg.failed)
        else $error("error result without failure latch");

    // Once failed and drained, no further results appear
    a_failed_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg.failed && !out_reg.valid) |=> !out_reg.valid)
        else $error("result produced in failed state");

    // Non-payload results carry a zero data byte
    a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_reg.valid && out_reg.kind != KIND_PAYLOAD) |-> (out_reg.data_byte == 8'd0))
        else $error("data byte set on non-payload result");

endmodule
